/* design/bse_pkg.sv */
// Shared types, constants and codes of the BMP LSB embedder.
package bse_pkg;

	localparam int HEADER_BYTES = 54;
	localparam int LEN_BYTES    = 32;
	localparam int POS_W        = 36;
	localparam int MSG_LEN_W    = 32;

	// Header byte positions that the format check looks at.
	localparam int POS_MAGIC_B  = 0;
	localparam int POS_MAGIC_M  = 1;
	localparam int POS_SIZE_0   = 2;
	localparam int POS_SIZE_1   = 3;
	localparam int POS_SIZE_2   = 4;
	localparam int POS_OFFS_0   = 10;
	localparam int POS_OFFS_1   = 11;
	localparam int POS_OFFS_2   = 12;
	localparam int POS_DEPTH    = 28;

	localparam logic [7:0] MAGIC_B    = 8'h42;
	localparam logic [7:0] MAGIC_M    = 8'h4D;
	localparam logic [7:0] DEPTH_24   = 8'd24;
	localparam logic [7:0] LSB_CLEAR  = 8'hFE;

	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [MSG_LEN_W-1:0] msg_len_t;

	typedef enum logic [1:0] {
		PHASE_HEADER  = 2'd0,
		PHASE_LENGTH  = 2'd1,
		PHASE_MESSAGE = 2'd2,
		PHASE_TAIL    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_FORMAT = 2'd1,
		STATUS_TOO_LONG   = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] cover_byte;
		logic [7:0] secret_byte;
		logic       end_of_file;
	} item_t;

	typedef struct packed {
		logic [7:0] stego_byte;
		phase_t     phase;
		status_t    status;
		logic       last_out;
	} result_t;

	// Per-file state; only the low two offset bytes are kept, the third is
	// compared as it arrives.
	typedef struct packed {
		pos_t        pos;
		logic [23:0] size_field;
		logic [15:0] offset_lo;
		logic [7:0]  shifter;
		status_t     status;
	} file_state_t;

endpackage

/* design/bse_item_if.sv */
// Channel interfaces of the BMP LSB embedder: cover bytes, stego bytes, configuration.
interface bse_cover_if;
	logic       valid;
	logic       ready;
	logic [7:0] cover_byte;
	logic [7:0] secret_byte;
	logic       end_of_file;

	modport source (output valid, output cover_byte, output secret_byte,
		output end_of_file, input ready);
	modport sink (input valid, input cover_byte, input secret_byte,
		input end_of_file, output ready);
endinterface

interface bse_stego_if;
	logic       valid;
	logic       ready;
	logic [7:0] stego_byte;
	logic [1:0] phase;
	logic [1:0] status;
	logic       last_out;

	modport source (output valid, output stego_byte, output phase, output status,
		output last_out, input ready);
	modport sink (input valid, input stego_byte, input phase, input status,
		input last_out, output ready);
endinterface

interface bse_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_length;

	modport source (output valid, output message_length, input ready);
	modport sink (input valid, input message_length, output ready);
endinterface

/* design/bse_embed_logic.sv */
// Per-byte embedding logic: header checks, LSB replacement and next file state.
module bse_embed_logic (
	input  bse_pkg::item_t       item,
	input  bse_pkg::file_state_t cur,
	input  bse_pkg::msg_len_t    msg_len,
	output bse_pkg::result_t     result,
	output bse_pkg::file_state_t nxt
);

	localparam bse_pkg::pos_t POS_LAST_HDR = bse_pkg::pos_t'(bse_pkg::HEADER_BYTES - 1);
	localparam bse_pkg::pos_t POS_LEN_END  =
		bse_pkg::pos_t'(bse_pkg::HEADER_BYTES + bse_pkg::LEN_BYTES);
	localparam bse_pkg::pos_t POS_HDR_END  = bse_pkg::pos_t'(bse_pkg::HEADER_BYTES);

	logic [bse_pkg::POS_W:0]   msg_end;
	logic [bse_pkg::POS_W-1:0] need;
	logic [4:0]                len_sel;
	logic [2:0]                k_low;
	logic [2:0]                msg_bit_idx;
	logic [7:0]                shift_src;
	logic                      in_message;
	logic                      lsb;
	bse_pkg::status_t          status_hdr;

	assign msg_end = {2'b00, msg_len, 3'b000} + (bse_pkg::POS_W+1)'(POS_LEN_END);
	assign need    = {1'b0, msg_len, 3'b000} + bse_pkg::pos_t'(bse_pkg::LEN_BYTES);
	assign in_message = ({1'b0, cur.pos} < msg_end);

	// Length bit: bytes of the length little-endian, bits MSB first.
	assign k_low   = cur.pos[2:0] - POS_HDR_END[2:0];
	assign len_sel = {cur.pos[4:3] - POS_HDR_END[4:3] - 2'(k_low > cur.pos[2:0]), ~k_low};

	// Bit position within the current message byte, which spans eight cover bytes.
	assign msg_bit_idx = cur.pos[2:0] - POS_LEN_END[2:0];
	assign shift_src   = (msg_bit_idx == 3'd0) ? item.secret_byte : cur.shifter;

	always_comb begin
		nxt        = cur;
		status_hdr = cur.status;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_MAGIC_B) && item.cover_byte != bse_pkg::MAGIC_B)
			status_hdr = bse_pkg::STATUS_BAD_FORMAT;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_MAGIC_M) && item.cover_byte != bse_pkg::MAGIC_M)
			status_hdr = bse_pkg::STATUS_BAD_FORMAT;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_SIZE_0))
			nxt.size_field[7:0] = item.cover_byte;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_SIZE_1))
			nxt.size_field[15:8] = item.cover_byte;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_SIZE_2))
			nxt.size_field[23:16] = item.cover_byte;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_OFFS_0))
			nxt.offset_lo[7:0] = item.cover_byte;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_OFFS_1))
			nxt.offset_lo[15:8] = item.cover_byte;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_OFFS_2) && cur.status == bse_pkg::STATUS_OK
				&& {item.cover_byte, cur.offset_lo} != 24'(bse_pkg::HEADER_BYTES))
			status_hdr = bse_pkg::STATUS_BAD_FORMAT;
		if (cur.pos == bse_pkg::pos_t'(bse_pkg::POS_DEPTH) && cur.status == bse_pkg::STATUS_OK
				&& item.cover_byte != bse_pkg::DEPTH_24)
			status_hdr = bse_pkg::STATUS_BAD_FORMAT;
		if (cur.pos == POS_LAST_HDR && cur.status == bse_pkg::STATUS_OK
				&& {12'd0, cur.size_field} < need)
			status_hdr = bse_pkg::STATUS_TOO_LONG;
		// The first error found in a file is the one that sticks.
		if (cur.status != bse_pkg::STATUS_OK)
			status_hdr = cur.status;

		lsb = 1'b0;
		result.stego_byte = item.cover_byte;
		result.last_out   = item.end_of_file;
		result.status     = cur.status;
		if (cur.pos < POS_HDR_END) begin
			result.phase  = bse_pkg::PHASE_HEADER;
			result.status = status_hdr;
			nxt.status    = status_hdr;
		end else if (cur.status != bse_pkg::STATUS_OK) begin
			result.phase = bse_pkg::PHASE_TAIL;
		end else if (cur.pos < POS_LEN_END) begin
			result.phase = bse_pkg::PHASE_LENGTH;
			lsb = msg_len[len_sel];
			result.stego_byte = (item.cover_byte & bse_pkg::LSB_CLEAR) | {7'd0, lsb};
		end else if (in_message) begin
			result.phase = bse_pkg::PHASE_MESSAGE;
			lsb = shift_src[7];
			result.stego_byte = (item.cover_byte & bse_pkg::LSB_CLEAR) | {7'd0, lsb};
			nxt.shifter = {shift_src[6:0], 1'b0};
		end else begin
			result.phase = bse_pkg::PHASE_TAIL;
		end

		if (item.end_of_file) begin
			nxt = '0;
		end else if (cur.pos != '1) begin
			nxt.pos = cur.pos + bse_pkg::pos_t'(1);
		end
	end

endmodule

/* design/bmp_lsb_stego_embedder.sv */
// Top level of the BMP LSB embedder: input register, embedding logic, result register.
//
// Usage: the cover channel takes one byte of a 24-bit BMP file per request,
// together with the current secret byte and an end-of-file mark. The stego
// channel returns exactly one request per accepted byte, in order. The
// configuration channel sets the message length in bytes; it is always ready
// and should only be written while no byte is in flight.
//
// A byte accepted is held in the input register, processed by the embedding
// logic and taken into the result register when the stego channel is free,
// then offered on the stego channel.
// Throughput: one byte per cycle while the receiver keeps up; the per-byte
// work is a position compare and one bit replacement between the two registers.
//
// Reset clears the position, the header fields, the status and the message
// length. The per-file state also clears after the byte marked end of file.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more byte, after which the cover channel
// drops ready until the stego channel moves again.
module bmp_lsb_stego_embedder (
	input logic        clk,
	input logic        arst_n,
	bse_cover_if.sink  bmp,
	bse_stego_if.source stego,
	bse_cfg_if.sink    cfg
);

	logic                  valid_s1;
	bse_pkg::item_t        item_s1;
	logic                  valid_s2;
	bse_pkg::result_t      result_s2;
	bse_pkg::file_state_t  state_q;
	bse_pkg::msg_len_t     msg_len_q;
	bse_pkg::result_t      result_comb;
	bse_pkg::file_state_t  state_nxt;
	logic                  out_free;
	logic                  advance;

	assign out_free  = !valid_s2 || stego.ready;
	assign advance   = valid_s1 && out_free;
	assign bmp.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	bse_embed_logic u_logic (
		.item    (item_s1),
		.cur     (state_q),
		.msg_len (msg_len_q),
		.result  (result_comb),
		.nxt     (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			state_q   <= '0;
			msg_len_q <= '0;
		end else begin
			if (bmp.ready)
				valid_s1 <= bmp.valid;
			if (out_free)
				valid_s2 <= valid_s1;
			if (advance)
				state_q <= state_nxt;
			if (cfg.valid)
				msg_len_q <= cfg.message_length;
		end
	end

	always_ff @(posedge clk) begin
		if (bmp.ready && bmp.valid) begin
			item_s1.cover_byte  <= bmp.cover_byte;
			item_s1.secret_byte <= bmp.secret_byte;
			item_s1.end_of_file <= bmp.end_of_file;
		end
		if (advance)
			result_s2 <= result_comb;
	end

	assign stego.valid      = valid_s2;
	assign stego.stego_byte = result_s2.stego_byte;
	assign stego.phase      = result_s2.phase;
	assign stego.status     = result_s2.status;
	assign stego.last_out   = result_s2.last_out;

endmodule

/* verif/bse_embed_checker.sv */
// Checker of the BMP LSB embedder: predicts each stego byte and compares it.
module bse_embed_checker (
	input  logic  clk,
	input  logic  arst_n,
	bse_cover_if  bmp,
	bse_stego_if  stego,
	bse_cfg_if    cfg,
	output int    mismatches,
	output int    results_waiting,
	output int    results_checked
);

	localparam logic [63:0] POS_LIMIT = (64'd1 << bse_pkg::POS_W) - 64'd1;

	bse_pkg::pos_t     file_pos;
	logic [23:0]       size_acc;
	logic [23:0]       offset_acc;
	logic [7:0]        secret_shift;
	bse_pkg::status_t  file_status;
	bse_pkg::msg_len_t msg_len;
	bse_pkg::result_t  stego_due [$];

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("stego byte %0d, %s: got 0x%0h, expected 0x%0h",
				results_checked, name, got, want));
	endtask

	function automatic void clear_file();
		file_pos     = '0;
		size_acc     = '0;
		offset_acc   = '0;
		secret_shift = '0;
		file_status  = bse_pkg::STATUS_OK;
	endfunction

	// The first error of a file is the one that sticks.
	function automatic void flag_status(input bse_pkg::status_t code);
		if (file_status == bse_pkg::STATUS_OK)
			file_status = code;
	endfunction

	function automatic bse_pkg::result_t embed_byte(input bse_pkg::item_t it);
		bse_pkg::result_t r;
		logic [63:0]      p;
		logic [63:0]      rel;
		logic [63:0]      need;
		int               k;
		int               sh;
		p = 64'(file_pos);
		r.stego_byte = it.cover_byte;
		r.last_out   = it.end_of_file;
		if (p < bse_pkg::HEADER_BYTES) begin
			r.phase = bse_pkg::PHASE_HEADER;
			if (p == bse_pkg::POS_MAGIC_B && it.cover_byte != bse_pkg::MAGIC_B)
				flag_status(bse_pkg::STATUS_BAD_FORMAT);
			if (p == bse_pkg::POS_MAGIC_M && it.cover_byte != bse_pkg::MAGIC_M)
				flag_status(bse_pkg::STATUS_BAD_FORMAT);
			if (p >= bse_pkg::POS_SIZE_0 && p <= bse_pkg::POS_SIZE_2)
				size_acc[8 * (int'(p) - bse_pkg::POS_SIZE_0) +: 8] = it.cover_byte;
			if (p >= bse_pkg::POS_OFFS_0 && p <= bse_pkg::POS_OFFS_2)
				offset_acc[8 * (int'(p) - bse_pkg::POS_OFFS_0) +: 8] = it.cover_byte;
			if (p == bse_pkg::POS_OFFS_2 && offset_acc != bse_pkg::HEADER_BYTES)
				flag_status(bse_pkg::STATUS_BAD_FORMAT);
			if (p == bse_pkg::POS_DEPTH && it.cover_byte != bse_pkg::DEPTH_24)
				flag_status(bse_pkg::STATUS_BAD_FORMAT);
			if (p == bse_pkg::HEADER_BYTES - 1) begin
				need = (64'(msg_len) << 3) + 64'(bse_pkg::LEN_BYTES);
				if (64'(size_acc) < need)
					flag_status(bse_pkg::STATUS_TOO_LONG);
			end
		end else if (file_status != bse_pkg::STATUS_OK) begin
			r.phase = bse_pkg::PHASE_TAIL;
		end else begin
			rel = p - bse_pkg::HEADER_BYTES;
			if (rel < bse_pkg::LEN_BYTES) begin
				// Length bytes go out little-endian, each byte MSB first.
				k  = int'(rel);
				sh = 8 * (k >> 3) + (7 - (k & 7));
				r.phase      = bse_pkg::PHASE_LENGTH;
				r.stego_byte = {it.cover_byte[7:1], msg_len[sh]};
			end else if (rel - bse_pkg::LEN_BYTES < (64'(msg_len) << 3)) begin
				r.phase = bse_pkg::PHASE_MESSAGE;
				if (((rel - bse_pkg::LEN_BYTES) & 64'd7) == 0)
					secret_shift = it.secret_byte;
				r.stego_byte = {it.cover_byte[7:1], secret_shift[7]};
				secret_shift = secret_shift << 1;
			end else begin
				r.phase = bse_pkg::PHASE_TAIL;
			end
		end
		r.status = file_status;
		if (it.end_of_file)
			clear_file();
		else if (p < POS_LIMIT)
			file_pos = file_pos + bse_pkg::pos_t'(1);
		return r;
	endfunction

	task automatic check_stego();
		bse_pkg::result_t want;
		if (stego_due.size() == 0) begin
			report_mismatch("stego request with no byte expected");
			return;
		end
		want = stego_due.pop_front();
		compare_field("stego_byte", stego.stego_byte, want.stego_byte);
		compare_field("phase", stego.phase, want.phase);
		compare_field("status", stego.status, want.status);
		compare_field("last_out", stego.last_out, want.last_out);
		results_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bse_pkg::item_t it;
		if (!arst_n) begin
			clear_file();
			msg_len = '0;
			stego_due.delete();
			mismatches      = 0;
			results_waiting = 0;
			results_checked = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				msg_len = cfg.message_length;
			if (stego.valid && stego.ready)
				check_stego();
			if (bmp.valid && bmp.ready) begin
				it.cover_byte  = bmp.cover_byte;
				it.secret_byte = bmp.secret_byte;
				it.end_of_file = bmp.end_of_file;
				stego_due.push_back(embed_byte(it));
			end
			results_waiting = stego_due.size();
		end
	end

endmodule

/* verif/bmp_lsb_stego_embedder_tb.sv */
// Testbench top of the BMP LSB embedder: clock, reset, cover file stimulus and verdict.
module bmp_lsb_stego_embedder_tb;

	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 140;
	localparam int HOLD_CYCLES  = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int mismatches;
	int results_waiting;
	int results_checked;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int hold_left     = 0;

	int bytes_sent    = 0;
	int files_sent    = 0;
	int broken_files  = 0;

	bse_cover_if cover_ch ();
	bse_stego_if stego_ch ();
	bse_cfg_if   cfg_ch ();

	bmp_lsb_stego_embedder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bmp    (cover_ch),
		.stego  (stego_ch),
		.cfg    (cfg_ch)
	);

	bse_embed_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.bmp             (cover_ch),
		.stego           (stego_ch),
		.cfg             (cfg_ch),
		.mismatches      (mismatches),
		.results_waiting (results_waiting),
		.results_checked (results_checked)
	);

	always #5 clk = ~clk;

	// Receiver side: random stalls, or a long hold-off when one is asked for.
	initial begin
		stego_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				stego_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				stego_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Timeout: the stego stream did not complete");
		$display("Test completed with failures");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic push_cover(input logic [7:0] c, input logic [7:0] s, input logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			cover_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cover_ch.valid       <= 1'b1;
		cover_ch.cover_byte  <= c;
		cover_ch.secret_byte <= s;
		cover_ch.end_of_file <= eof;
		do
			@(posedge clk);
		while (!cover_ch.ready);
		@(negedge clk);
		bytes_sent++;
		if (eof)
			files_sent++;
	endtask

	task automatic set_message_length(input bse_pkg::msg_len_t len);
		cover_ch.valid <= 1'b0;
		while (results_waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.message_length <= len;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_file(input bse_pkg::msg_len_t len);
		logic [7:0]  hdr [bse_pkg::HEADER_BYTES];
		logic [63:0] need;
		logic [23:0] size_val;
		int unsigned room;
		int          kind;
		int          total;
		int          body;
		int          spot;
		int          i;
		logic [7:0]  c;
		need = (64'(len) << 3) + 64'(bse_pkg::LEN_BYTES);
		for (i = 0; i < bse_pkg::HEADER_BYTES; i++)
			hdr[i] = 8'($urandom_range(255));
		if (need <= 64'hFF_FFFF) begin
			room = 32'hFF_FFFF - need[31:0];
			case ($urandom_range(3))
				0: size_val = need[23:0];
				1: size_val = 24'hFF_FFFF;
				default: size_val = need[23:0] + 24'($urandom_range(room));
			endcase
		end else begin
			size_val = 24'($urandom);
		end
		kind = $urandom_range(99);
		// A size field smaller than what the message needs.
		if (kind >= 80 && kind < 90 && need <= 64'hFF_FFFF)
			size_val = 24'(need[31:0] - 1 - $urandom_range(need[31:0] - 1));
		hdr[bse_pkg::POS_MAGIC_B] = bse_pkg::MAGIC_B;
		hdr[bse_pkg::POS_MAGIC_M] = bse_pkg::MAGIC_M;
		hdr[bse_pkg::POS_SIZE_0]  = size_val[7:0];
		hdr[bse_pkg::POS_SIZE_1]  = size_val[15:8];
		hdr[bse_pkg::POS_SIZE_2]  = size_val[23:16];
		hdr[bse_pkg::POS_OFFS_0]  = 8'(bse_pkg::HEADER_BYTES);
		hdr[bse_pkg::POS_OFFS_1]  = 8'd0;
		hdr[bse_pkg::POS_OFFS_2]  = 8'd0;
		hdr[bse_pkg::POS_DEPTH]   = bse_pkg::DEPTH_24;
		if (kind >= 70 && kind < 80) begin
			case ($urandom_range(5))
				0: spot = bse_pkg::POS_MAGIC_B;
				1: spot = bse_pkg::POS_MAGIC_M;
				2: spot = bse_pkg::POS_OFFS_0;
				3: spot = bse_pkg::POS_OFFS_1;
				4: spot = bse_pkg::POS_OFFS_2;
				default: spot = bse_pkg::POS_DEPTH;
			endcase
			hdr[spot] = hdr[spot] ^ 8'(1 << $urandom_range(7));
		end
		if (kind >= 70 && kind < 90)
			broken_files++;
		if (kind >= 95) begin
			for (i = 0; i < bse_pkg::HEADER_BYTES; i++)
				hdr[i] = 8'($urandom_range(255));
			total = $urandom_range(1, 120);
		end else if (kind >= 90) begin
			total = $urandom_range(1, bse_pkg::HEADER_BYTES);
		end else if (kind >= 70) begin
			total = bse_pkg::HEADER_BYTES + $urandom_range(0, 24);
		end else begin
			if (len <= 12 && $urandom_range(9) != 0)
				body = bse_pkg::LEN_BYTES + 8 * int'(len) + $urandom_range(0, 10);
			else if (len <= 12)
				body = $urandom_range(0, bse_pkg::LEN_BYTES + 8 * int'(len));
			else
				body = $urandom_range(0, bse_pkg::LEN_BYTES + 96);
			total = bse_pkg::HEADER_BYTES + body;
		end
		for (i = 0; i < total; i++) begin
			c = (i < bse_pkg::HEADER_BYTES) ? hdr[i] : 8'($urandom_range(255));
			push_cover(c, 8'($urandom_range(255)), i == total - 1);
		end
	endtask

	initial begin
		bse_pkg::msg_len_t lengths [PHASES];
		int                ph;
		int                phase_end;
		cover_ch.valid        = 1'b0;
		cover_ch.cover_byte   = '0;
		cover_ch.secret_byte  = '0;
		cover_ch.end_of_file  = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.message_length = '0;
		lengths = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'h001F_FFFB, 32'd12,
			32'h0020_0000, bse_pkg::msg_len_t'($urandom_range(2, 8))};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Short files at the reset length: one-byte files at both byte extremes,
		// a truncated header and two files with a broken magic.
		push_cover(8'hFF, 8'h00, 1'b1);
		push_cover(8'h00, 8'hFF, 1'b1);
		push_cover(bse_pkg::MAGIC_B, 8'hAA, 1'b0);
		push_cover(bse_pkg::MAGIC_M, 8'h55, 1'b0);
		push_cover(8'h36, 8'hFF, 1'b0);
		push_cover(8'h00, 8'h00, 1'b1);
		push_cover(8'h58, 8'h01, 1'b0);
		push_cover(bse_pkg::MAGIC_M, 8'h80, 1'b0);
		push_cover(8'hFE, 8'h7F, 1'b1);
		push_cover(bse_pkg::MAGIC_B, 8'hFF, 1'b0);
		push_cover(8'h4E, 8'h00, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			set_message_length(lengths[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			// Sender keeps offering while the receiver holds off, so the block fills.
			if (ph == 4)
				hold_req = HOLD_CYCLES;
			phase_end = bytes_sent + PHASE_ITEMS;
			while (bytes_sent < phase_end)
				send_file(lengths[ph]);
		end

		cover_ch.valid <= 1'b0;
		stall_pct     = 0;
		while (results_waiting != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);

		$display("Sent %0d cover bytes in %0d files over %0d message lengths, %0d of them with a",
			bytes_sent, files_sent, PHASES + 1, broken_files);
		$display("broken header or too small a size field; %0d stego bytes checked, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/bse_pkg.sv
design/bse_item_if.sv
design/bse_embed_logic.sv
design/bmp_lsb_stego_embedder.sv
verif/bse_embed_checker.sv
verif/bmp_lsb_stego_embedder_tb.sv
